/* rtl/ttps_pkg.sv */
package ttps_pkg;

    localparam int INDEX_BITS_DEFAULT = 12;
    localparam int MOVE_BITS_DEFAULT  = 4;

    localparam logic [3:0] INDEX_BITS_IN_USE_RESET = 4'd12;

    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;
    localparam logic [1:0] BOUND_EXACT = 2'd3;

    typedef struct packed {
        logic              command;
        logic [63:0]       key;
        logic [7:0]        depth;
        logic signed [7:0] alpha;
        logic signed [7:0] beta;
        logic signed [7:0] store_value;
        logic [3:0]        best_move;
        logic [1:0]        bound_kind;
    } request_t;

    typedef struct packed {
        logic              hit;
        logic signed [7:0] result_value;
        logic              collision;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

/* rtl/ttps_ram.sv */
module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/transposition_table_probe_store_core.sv */
// Direct-mapped, always-replace transposition table. After reset the block runs a clearing
// pass over all 2**INDEX_BITS entries (4096 at the default) with busy high; configuration
// writes are taken during it. An item (probe or store) is taken when start is high and busy
// is low. The table read is registered on acceptance; the compare state then checks the
// entry and writes it back on a store; a new item is taken only after the compare. The
// result shows on result for exactly one cycle with done high, in the cycle after the
// compare, and must be taken then: the receiver cannot stall the block. The user is to
// write index_bits_in_use through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block does not enforce this. 0 acts as 1, values above INDEX_BITS as INDEX_BITS.
module transposition_table_probe_store_core #(
    parameter int INDEX_BITS = ttps_pkg::INDEX_BITS_DEFAULT,
    parameter int MOVE_BITS  = ttps_pkg::MOVE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ttps_pkg::request_t request,
    output logic               done,
    output ttps_pkg::result_t  result,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data
);

    import ttps_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    typedef struct packed {
        logic [63:0]          tag;
        logic signed [7:0]    value;
        logic [1:0]           flag;
        logic [7:0]           depth;
        logic [MOVE_BITS-1:0] move;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    state_t                state_reg;
    state_t                state_next;
    logic [3:0]            cfg_reg;
    logic [INDEX_BITS-1:0] clr_idx_reg;
    logic [INDEX_BITS-1:0] clr_idx_next;
    request_t              item_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic                  done_reg;
    logic                  done_next;
    result_t               result_reg;
    result_t               result_next;

    logic [INDEX_BITS-1:0] index_mask;
    logic [INDEX_BITS-1:0] rd_index;
    logic                  accept;

    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    entry_t                ram_wdata;
    entry_t                ram_rdata;

    logic                  tag_match;
    logic                  deep;
    logic signed [7:0]     e_value;
    logic signed [7:0]     c_alpha;
    logic signed [7:0]     c_beta;

    // index mask from the register, saturating at both ends
    always_comb
    begin
        for (int i = 0; i < INDEX_BITS; i++)
        begin
            index_mask[i] = (i == 0) || (i < int'(cfg_reg));
        end
    end

    assign rd_index = request.key[INDEX_BITS-1:0] & index_mask;
    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign result   = result_reg;

    ttps_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_index),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign e_value   = ram_rdata.value;
    assign c_alpha   = item_reg.alpha;
    assign c_beta    = item_reg.beta;
    assign tag_match = (ram_rdata.tag == item_reg.key);
    assign deep      = (ram_rdata.depth >= item_reg.depth);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        done_next    = 1'b0;
        result_next  = '0;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (item_reg.command == CMD_STORE)
                begin
                    ram_we                = 1'b1;
                    ram_wdata.tag         = item_reg.key;
                    ram_wdata.value       = item_reg.store_value;
                    ram_wdata.flag        = item_reg.bound_kind;
                    ram_wdata.depth       = item_reg.depth;
                    ram_wdata.move        = MOVE_BITS'(item_reg.best_move);
                    result_next.collision = (ram_rdata.tag != '0) && !tag_match;
                end
                else if (tag_match)
                begin
                    case (ram_rdata.flag)
                        BOUND_EXACT:
                        begin
                            result_next.hit = deep;
                            // alpha side is tested first when the window is inverted
                            if (e_value < c_alpha)
                            begin
                                result_next.result_value = c_alpha;
                            end
                            else if (c_beta < e_value)
                            begin
                                result_next.result_value = c_beta;
                            end
                            else
                            begin
                                result_next.result_value = e_value;
                            end
                        end
                        BOUND_UPPER:
                        begin
                            result_next.hit          = deep && (e_value <= c_alpha);
                            result_next.result_value = c_alpha;
                        end
                        BOUND_LOWER:
                        begin
                            result_next.hit          = deep && (e_value >= c_beta);
                            result_next.result_value = c_beta;
                        end
                        default:
                        begin
                            result_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= INDEX_BITS_IN_USE_RESET;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            clr_idx_reg <= clr_idx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            item_reg <= request;
            idx_reg  <= rd_index;
        end
    end

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("done without a compare cycle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC) && !done)
        else $error("accepted item did not move to compare");

    a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && item_reg.command == CMD_STORE)
        |=> done && !result.hit && (result.result_value == 8'sd0))
        else $error("store result carries probe fields");

    a_probe_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && item_reg.command == CMD_PROBE) |=> done && !result.collision)
        else $error("probe flagged a collision");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("table written while idle");

endmodule

/* dv/transposition_table_probe_store_core_tb.sv */
`timescale 1ns / 100ps

module transposition_table_probe_store_core_tb;

    import ttps_pkg::*;

    localparam int TABLE_DEPTH = 1 << INDEX_BITS_DEFAULT;
    localparam int PHASE_ITEMS = 130;
    localparam int MAX_GAP     = 11;
    localparam int KEY_POOL    = 24;

    typedef struct {
        logic [63:0]       tag;
        logic signed [7:0] score;
        logic [1:0]        flag;
        logic [7:0]        depth;
        logic [3:0]        move;
    } tt_slot_t;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  res;
    } directed_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    request_t   request;
    logic       done;
    result_t    result;
    logic       cfg_wr_en;
    logic [3:0] cfg_wr_data;

    tt_slot_t      slot_mirror [TABLE_DEPTH];
    int            index_width;
    result_t       pending_results [$];
    directed_row_t directed_rows [$];
    logic [63:0]   stored_keys [$];

    int  mismatch_count;
    int  probe_count;
    int  store_count;
    int  hit_count;
    int  collision_count;
    int  width_settings;
    bit  burst_mode;

    transposition_table_probe_store_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // mirror of the table: answers a probe or applies a store
    function automatic result_t tt_lookup_update(input request_t r);
        result_t           res;
        int                n;
        int                idx;
        logic [63:0]       mask;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        logic signed [7:0] val;
        bit                deep;
        n = index_width;
        if (n < 1)
            n = 1;
        if (n > INDEX_BITS_DEFAULT)
            n = INDEX_BITS_DEFAULT;
        mask = (64'd1 << n) - 64'd1;
        idx = int'(r.key & mask);
        lo = r.alpha;
        hi = r.beta;
        val = slot_mirror[idx].score;
        deep = slot_mirror[idx].depth >= r.depth;
        res = '0;
        if (r.command == CMD_STORE)
        begin
            res.collision = (slot_mirror[idx].tag != 64'd0) && (slot_mirror[idx].tag != r.key);
            slot_mirror[idx].tag = r.key;
            slot_mirror[idx].score = r.store_value;
            slot_mirror[idx].flag = r.bound_kind;
            slot_mirror[idx].depth = r.depth;
            slot_mirror[idx].move = r.best_move;
        end
        else if (slot_mirror[idx].tag == r.key)
        begin
            case (slot_mirror[idx].flag)
                BOUND_EXACT:
                begin
                    res.hit = deep;
                    // alpha is tested first, so an inverted window favors alpha
                    if (val < lo)
                        res.result_value = lo;
                    else if (hi < val)
                        res.result_value = hi;
                    else
                        res.result_value = val;
                end
                BOUND_UPPER:
                begin
                    res.hit = deep && (val <= lo);
                    res.result_value = lo;
                end
                BOUND_LOWER:
                begin
                    res.hit = deep && (val >= hi);
                    res.result_value = hi;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic request_t make_req(input logic cmd, input logic [63:0] key,
                                          input logic [7:0] depth, input logic [7:0] alpha,
                                          input logic [7:0] beta, input logic [7:0] sval,
                                          input logic [3:0] move, input logic [1:0] kind);
        request_t r;
        r.command = cmd;
        r.key = key;
        r.depth = depth;
        r.alpha = alpha;
        r.beta = beta;
        r.store_value = sval;
        r.best_move = move;
        r.bound_kind = kind;
        return r;
    endfunction

    function automatic void add_row(input request_t r, input bit typed, input logic hit,
                                    input logic [7:0] value, input logic coll);
        directed_row_t row;
        row.req = r;
        row.typed = typed;
        row.res.hit = hit;
        row.res.result_value = value;
        row.res.collision = coll;
        directed_rows.push_back(row);
    endfunction

    function automatic request_t make_random_item();
        request_t    r;
        int          pick;
        logic [63:0] k;
        logic [7:0]  a;
        logic [7:0]  b;
        r.command = ($urandom_range(0, 99) < 45) ? CMD_STORE : CMD_PROBE;
        pick = $urandom_range(0, 99);
        k = {$urandom, $urandom};
        if (pick < 55 && stored_keys.size() > 0)
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (pick < 70 && stored_keys.size() > 0)
            // same slot, different tag
            k = {k[63:12], stored_keys[$urandom_range(0, stored_keys.size() - 1)][11:0]};
        else if (pick < 75)
            k = 64'd0;
        r.key = k;
        r.depth = 8'($urandom_range(0, 255));
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 60 && $signed(a) > $signed(b))
        begin
            r.alpha = b;
            r.beta = a;
        end
        else
        begin
            r.alpha = a;
            r.beta = b;
        end
        r.store_value = 8'($urandom_range(0, 255));
        r.best_move = 4'($urandom_range(0, 15));
        r.bound_kind = 2'($urandom_range(0, 3));
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic issue_item(input request_t r, input bit typed, input result_t typed_res);
        int      gap;
        result_t predicted;
        if ($urandom_range(0, 29) == 0)
            burst_mode = !burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = tt_lookup_update(r);
        pending_results.push_back(typed ? typed_res : predicted);
        if (r.command == CMD_STORE)
        begin
            store_count++;
            stored_keys.push_back(r.key);
            if (stored_keys.size() > KEY_POOL)
                void'(stored_keys.pop_front());
        end
        else
            probe_count++;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_index_width(input logic [3:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        index_width = int'(value);
        width_settings++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual hit=%0b value=%0d coll=%0b",
                         $time, result.hit, result.result_value, result.collision);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.hit !== want.hit)
                begin
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $time, want.hit, result.hit);
                    mismatch_count++;
                end
                if (result.result_value !== want.result_value)
                begin
                    $display("%0t: result_value mismatch, expected %0d actual %0d",
                             $time, want.result_value, result.result_value);
                    mismatch_count++;
                end
                if (result.collision !== want.collision)
                begin
                    $display("%0t: collision mismatch, expected %0b actual %0b",
                             $time, want.collision, result.collision);
                    mismatch_count++;
                end
                if (result.hit === 1'b1)
                    hit_count++;
                if (result.collision === 1'b1)
                    collision_count++;
            end
        end
    end

    initial
    begin
        logic [3:0] widths [8];
        result_t    none;
        request_t   r;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 4'd0;
        mismatch_count = 0;
        probe_count = 0;
        store_count = 0;
        hit_count = 0;
        collision_count = 0;
        width_settings = 1;
        burst_mode = 1'b0;
        index_width = int'(INDEX_BITS_IN_USE_RESET);
        none = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_mirror[i] = '{default: '0};
        widths = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd12, 4'd6, 4'd13, 4'd9};

        // cleared table, full index width
        add_row(make_req(CMD_PROBE, 64'd0, 8'd0, -8'sd128, 8'sd127, 8'd0, 4'd0, BOUND_NONE),
                1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_PROBE, '1, 8'd255, 8'sd127, -8'sd128, 8'd0, 4'd0, BOUND_NONE),
                1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_STORE, 64'h0123_4567_89AB_C005, 8'd20, 8'd0, 8'd0, 8'sd10,
                         4'd15, BOUND_EXACT), 1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h0123_4567_89AB_C005, 8'd20, -8'sd128, 8'sd127, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b1, 8'sd10, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h0123_4567_89AB_C005, 8'd21, -8'sd128, 8'sd127, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b0, 8'sd10, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h0123_4567_89AB_C005, 8'd0, 8'sd20, 8'sd127, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b1, 8'sd20, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h0123_4567_89AB_C005, 8'd0, -8'sd128, 8'sd5, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b1, 8'sd5, 1'b0);
        // inverted window with the value below alpha
        add_row(make_req(CMD_PROBE, 64'h0123_4567_89AB_C005, 8'd0, 8'sd30, 8'sd5, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b1, 8'sd30, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h0123_4567_89AB_C005, 8'd3, 8'sd9, 8'sd2, 8'd0,
                         4'd0, BOUND_NONE), 0, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_STORE, 64'hFFFF_0000_0000_0005, 8'd7, 8'd0, 8'd0, -8'sd1,
                         4'd0, BOUND_EXACT), 1, 1'b0, 8'd0, 1'b1);
        add_row(make_req(CMD_PROBE, 64'h0123_4567_89AB_C005, 8'd0, -8'sd128, 8'sd127, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_STORE, 64'h8000_0000_0000_0001, 8'd255, 8'd0, 8'd0, -8'sd50,
                         4'd5, BOUND_UPPER), 1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h8000_0000_0000_0001, 8'd255, -8'sd50, 8'sd0, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b1, -8'sd50, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h8000_0000_0000_0001, 8'd0, -8'sd51, 8'sd0, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b0, -8'sd51, 1'b0);
        add_row(make_req(CMD_STORE, 64'h7FFF_FFFF_FFFF_F002, 8'd0, 8'd0, 8'd0, 8'sd127,
                         4'd10, BOUND_LOWER), 1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h7FFF_FFFF_FFFF_F002, 8'd0, -8'sd128, 8'sd127, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b1, 8'sd127, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h7FFF_FFFF_FFFF_F002, 8'd1, 8'sd0, -8'sd128, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b0, -8'sd128, 1'b0);
        // store with an empty flag leaves a tag that never answers
        add_row(make_req(CMD_STORE, 64'h5555_AAAA_5555_A003, 8'd9, 8'd0, 8'd0, 8'sd99,
                         4'd3, BOUND_NONE), 1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_PROBE, 64'h5555_AAAA_5555_A003, 8'd0, -8'sd128, 8'sd127, 8'd0,
                         4'd0, BOUND_NONE), 1, 1'b0, 8'd0, 1'b0);
        // zero key: overwriting a zero tag is not a collision
        add_row(make_req(CMD_STORE, 64'd0, 8'd0, 8'd0, 8'd0, -8'sd128, 4'd0, BOUND_EXACT),
                1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_PROBE, 64'd0, 8'd0, -8'sd128, 8'sd127, 8'd0, 4'd0, BOUND_NONE),
                1, 1'b1, -8'sd128, 1'b0);
        add_row(make_req(CMD_STORE, 64'h0000_0000_0000_1000, 8'd1, 8'd0, 8'd0, 8'sd3,
                         4'd1, BOUND_LOWER), 1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_STORE, 64'h0000_0000_0000_1000, 8'd2, 8'd0, 8'd0, 8'sd4,
                         4'd2, BOUND_UPPER), 1, 1'b0, 8'd0, 1'b0);
        add_row(make_req(CMD_STORE, 64'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 4'd0, BOUND_EXACT),
                1, 1'b0, 8'd0, 1'b1);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            issue_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        wait_results_drained();

        foreach (widths[p])
        begin
            write_index_width(widths[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = make_random_item();
                issue_item(r, 0, none);
                if ($urandom_range(0, 99) == 0)
                    wait_results_drained();
            end
            wait_results_drained();
        end

        repeat (8) @(negedge clk);
        $display("covered %0d probes (%0d hits) and %0d stores (%0d collisions)",
                 probe_count, hit_count, store_count, collision_count);
        $display("over %0d index width settings, including 0 and 15", width_settings);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
